/* design/vdj_pkg.sv */
// ----------------------------------------------------------------------------
// vdj_pkg
// Shared widths, register indexes and controller/datapath command types for
// the vertical diffusion Jacobi sweep block.
// ----------------------------------------------------------------------------
package vdj_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int THICK_W   = 32;
    localparam int REG_W     = 32;
    localparam int ACC_W     = 64;
    localparam int DIVD_W    = 64;
    localparam int DIVS_W    = 34;
    localparam int G_W       = 30;
    localparam int MUL_W     = 33;
    localparam int CNT_W     = $clog2(DIVD_W);

    localparam logic [G_W-1:0] COUPLING_MAX = '1;

    // Configuration register indexes.
    localparam logic CFG_VISCOSITY = 1'b0;
    localparam logic CFG_TIME_STEP = 1'b1;

    typedef struct packed {
        logic capture;
        logic shift;
        logic mul_p;
        logic div_start;
        logic div_sel_solve;
        logic div_sel_below;
        logic store_ga;
        logic store_gb;
        logic mul1;
        logic mul2;
        logic acc2;
        logic load_out;
        logic kind_final;
    } vdj_cmd_t;

    typedef struct packed {
        logic [1:0] held;
        logic       last;
        logic       div_busy;
        logic       out_free;
    } vdj_stat_t;

endpackage

/* design/vdj_div.sv */
// ----------------------------------------------------------------------------
// vdj_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vdj_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vdj_pkg::DIVD_W-1:0]  dividend,
    input  logic [vdj_pkg::DIVS_W-1:0]  divisor,
    output logic                        busy,
    output logic [vdj_pkg::DIVD_W-1:0]  quotient,
    output logic [vdj_pkg::DIVS_W-1:0]  remainder,
    output logic [vdj_pkg::DIVS_W-1:0]  divisor_q
);

    logic [vdj_pkg::DIVD_W-1:0] quo_reg;
    logic [vdj_pkg::DIVS_W-1:0] rem_reg;
    logic [vdj_pkg::DIVS_W-1:0] div_reg;
    logic [vdj_pkg::CNT_W-1:0]  cnt_reg;
    logic                       busy_reg;

    logic [vdj_pkg::DIVS_W:0]   rem_sh;
    logic [vdj_pkg::DIVS_W:0]   diff;
    logic                       ge;

    assign rem_sh = {rem_reg, quo_reg[vdj_pkg::DIVD_W-1]};
    assign ge     = rem_sh >= {1'b0, div_reg};
    assign diff   = rem_sh - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == vdj_pkg::CNT_W'(vdj_pkg::DIVD_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[vdj_pkg::DIVD_W-2:0], ge};
            rem_reg <= ge ? diff[vdj_pkg::DIVS_W-1:0] : rem_sh[vdj_pkg::DIVS_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign divisor_q = div_reg;

endmodule

/* design/vdj_dp.sv */
// ----------------------------------------------------------------------------
// vdj_dp
// Datapath: configuration, layer window, shared multiplier, accumulator,
// divider and the output register.
// ----------------------------------------------------------------------------
module vdj_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [vdj_pkg::REG_W-1:0]          cfg_data,
    input  logic [vdj_pkg::THICK_W-1:0]        layer_thickness,
    input  logic signed [vdj_pkg::VALUE_W-1:0] layer_value,
    input  logic signed [vdj_pkg::VALUE_W-1:0] layer_rhs,
    input  logic                               last_layer,
    input  vdj_pkg::vdj_cmd_t                  cmd,
    output vdj_pkg::vdj_stat_t                 stat,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [vdj_pkg::VALUE_W-1:0] new_value,
    output logic                               column_done,
    output logic                               saturated
);

    localparam logic [vdj_pkg::DIVD_W-1:0] LIM = vdj_pkg::DIVD_W'(1) << (vdj_pkg::VALUE_W - 1);

    logic [vdj_pkg::REG_W-1:0]          visc_reg, ts_reg;
    logic [vdj_pkg::THICK_W-1:0]        dz_in_reg, tb_reg, tm_reg;
    logic signed [vdj_pkg::VALUE_W-1:0] x_in_reg, rhs_in_reg, vb_reg, vm_reg, rm_reg;
    logic                               last_in_reg;
    logic [1:0]                         held_reg;
    logic [vdj_pkg::G_W-1:0]            ga_reg, gb_reg;
    logic signed [vdj_pkg::ACC_W-1:0]   prod_reg, acc_reg;
    logic [vdj_pkg::DIVS_W-1:0]         den_reg;
    logic                               neg_reg;
    logic                               out_valid_reg;
    logic signed [vdj_pkg::VALUE_W-1:0] val_reg;
    logic                               done_reg, sat_reg;

    logic [vdj_pkg::G_W-1:0]            g1, g2;
    logic signed [vdj_pkg::VALUE_W-1:0] x1, x2, rhs_s;
    logic [vdj_pkg::THICK_W-1:0]        dz_s;
    logic signed [vdj_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*vdj_pkg::MUL_W-1:0] mul_full;
    logic [vdj_pkg::ACC_W-1:0]          mag;
    logic                               div_start;
    logic [vdj_pkg::DIVD_W-1:0]         div_dividend;
    logic [vdj_pkg::DIVS_W-1:0]         div_divisor;
    logic                               div_busy;
    logic [vdj_pkg::DIVD_W-1:0]         quo;
    logic [vdj_pkg::DIVS_W-1:0]         rem, divq;
    logic                               half_up;
    logic [31:0]                        g_wide;
    logic [vdj_pkg::G_W-1:0]            g_calc;
    logic signed [vdj_pkg::VALUE_W-1:0] res_val;
    logic                               res_sat;
    logic [1:0]                         held_next;

    // Operand selection: the first result of an item uses both neighbors of
    // the middle layer, the final one uses the new top layer and the layer
    // below it.
    always_comb
    begin
        if (cmd.kind_final)
        begin
            g1    = ga_reg;
            x1    = vm_reg;
            g2    = '0;
            x2    = '0;
            dz_s  = dz_in_reg;
            rhs_s = rhs_in_reg;
        end
        else
        begin
            g1    = gb_reg;
            x1    = vb_reg;
            g2    = ga_reg;
            x2    = x_in_reg;
            dz_s  = tm_reg;
            rhs_s = rm_reg;
        end
    end

    always_comb
    begin
        if (cmd.mul_p)
        begin
            mul_a = signed'({1'b0, visc_reg});
            mul_b = signed'({1'b0, ts_reg});
        end
        else if (cmd.mul2)
        begin
            mul_a = signed'({3'b000, g2});
            mul_b = vdj_pkg::MUL_W'(x2);
        end
        else
        begin
            mul_a = signed'({3'b000, g1});
            mul_b = vdj_pkg::MUL_W'(x1);
        end
    end

    assign mul_full = mul_a * mul_b;

    assign mag = acc_reg[vdj_pkg::ACC_W-1] ? vdj_pkg::ACC_W'(-acc_reg) : vdj_pkg::ACC_W'(acc_reg);

    assign div_start    = cmd.div_start;
    assign div_dividend = cmd.div_sel_solve ? mag : vdj_pkg::DIVD_W'(prod_reg);
    assign div_divisor  = cmd.div_sel_solve ? den_reg :
                          vdj_pkg::DIVS_W'(tm_reg) +
                          vdj_pkg::DIVS_W'(cmd.div_sel_below ? tb_reg : dz_in_reg);

    vdj_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem),
        .divisor_q (divq)
    );

    // Coupling is floor(2p/s): twice the quotient plus one when the doubled
    // remainder reaches the divisor, clipped to the coupling limit.
    always_comb
    begin
        half_up = {rem, 1'b0} >= {1'b0, divq};
        g_wide  = {quo[30:0], 1'b0} + {31'd0, half_up};
        if (quo >= vdj_pkg::DIVD_W'(vdj_pkg::COUPLING_MAX))
        begin
            g_calc = vdj_pkg::COUPLING_MAX;
        end
        else if (g_wide > 32'(vdj_pkg::COUPLING_MAX))
        begin
            g_calc = vdj_pkg::COUPLING_MAX;
        end
        else
        begin
            g_calc = g_wide[vdj_pkg::G_W-1:0];
        end
    end

    always_comb
    begin
        res_sat = 1'b0;
        if (neg_reg)
        begin
            if (quo > LIM)
            begin
                res_sat = 1'b1;
                res_val = signed'(LIM[vdj_pkg::VALUE_W-1:0]);
            end
            else
            begin
                res_val = signed'(-quo[vdj_pkg::VALUE_W-1:0]);
            end
        end
        else if (quo > LIM - 1'b1)
        begin
            res_sat = 1'b1;
            res_val = signed'(vdj_pkg::VALUE_W'(LIM - 1'b1));
        end
        else
        begin
            res_val = signed'(quo[vdj_pkg::VALUE_W-1:0]);
        end
    end

    always_comb
    begin
        if (last_in_reg)
        begin
            held_next = 2'd0;
        end
        else if (held_reg == 2'd0)
        begin
            held_next = 2'd1;
        end
        else
        begin
            held_next = 2'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visc_reg      <= vdj_pkg::REG_W'(65536);
            ts_reg        <= vdj_pkg::REG_W'(65536);
            held_reg      <= 2'd0;
            tb_reg        <= '0;
            vb_reg        <= '0;
            tm_reg        <= '0;
            vm_reg        <= '0;
            rm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == vdj_pkg::CFG_VISCOSITY)
            begin
                visc_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == vdj_pkg::CFG_TIME_STEP)
            begin
                ts_reg <= cfg_data;
            end
            if (cmd.shift)
            begin
                held_reg <= held_next;
                tb_reg   <= tm_reg;
                vb_reg   <= vm_reg;
                tm_reg   <= dz_in_reg;
                vm_reg   <= x_in_reg;
                rm_reg   <= rhs_in_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dz_in_reg   <= (layer_thickness == '0) ? vdj_pkg::THICK_W'(1) : layer_thickness;
            x_in_reg    <= layer_value;
            rhs_in_reg  <= layer_rhs;
            last_in_reg <= last_layer;
            ga_reg      <= '0;
            gb_reg      <= '0;
        end
        if (cmd.store_ga)
        begin
            ga_reg <= g_calc;
        end
        if (cmd.store_gb)
        begin
            gb_reg <= g_calc;
        end
        if (cmd.mul_p || cmd.mul1 || cmd.mul2)
        begin
            prod_reg <= mul_full[vdj_pkg::ACC_W-1:0];
        end
        if (cmd.mul1)
        begin
            acc_reg <= vdj_pkg::ACC_W'(rhs_s) <<< vdj_pkg::FRAC_BITS;
        end
        else if (cmd.mul2 || cmd.acc2)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.acc2)
        begin
            den_reg <= vdj_pkg::DIVS_W'(g1) + vdj_pkg::DIVS_W'(g2) + vdj_pkg::DIVS_W'(dz_s);
        end
        if (cmd.div_start && cmd.div_sel_solve)
        begin
            neg_reg <= acc_reg[vdj_pkg::ACC_W-1];
        end
        if (cmd.load_out)
        begin
            val_reg  <= res_val;
            sat_reg  <= res_sat;
            done_reg <= cmd.kind_final;
        end
    end

    assign stat.held     = held_reg;
    assign stat.last     = last_in_reg;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign new_value   = val_reg;
    assign column_done = done_reg;
    assign saturated   = sat_reg;

endmodule

/* design/vdj_ctrl.sv */
// ----------------------------------------------------------------------------
// vdj_ctrl
// Controller: sequences couplings, numerator build-up, the division and the
// result hand-off for each accepted layer.
// ----------------------------------------------------------------------------
module vdj_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output vdj_pkg::vdj_cmd_t  cmd,
    input  vdj_pkg::vdj_stat_t stat
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECIDE    = 4'd1;
    localparam logic [3:0] S_MULP      = 4'd2;
    localparam logic [3:0] S_DIVA_GO   = 4'd3;
    localparam logic [3:0] S_DIVA_WAIT = 4'd4;
    localparam logic [3:0] S_DIVB_GO   = 4'd5;
    localparam logic [3:0] S_DIVB_WAIT = 4'd6;
    localparam logic [3:0] S_MUL1      = 4'd7;
    localparam logic [3:0] S_MUL2      = 4'd8;
    localparam logic [3:0] S_ACC2      = 4'd9;
    localparam logic [3:0] S_DIVS_GO   = 4'd10;
    localparam logic [3:0] S_DIVS_WAIT = 4'd11;
    localparam logic [3:0] S_OUT       = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.kind_final = kind_reg;
        in_stall       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.held == 2'd0)
                begin
                    if (stat.last)
                    begin
                        // A lone layer: both couplings stay zero.
                        kind_next  = 1'b1;
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        cmd.shift  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    kind_next  = 1'b0;
                    state_next = S_MULP;
                end
            end
            S_MULP:
            begin
                cmd.mul_p  = 1'b1;
                state_next = S_DIVA_GO;
            end
            S_DIVA_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVA_WAIT;
            end
            S_DIVA_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.store_ga = 1'b1;
                    state_next   = (stat.held == 2'd1) ? S_MUL1 : S_DIVB_GO;
                end
            end
            S_DIVB_GO:
            begin
                cmd.div_start     = 1'b1;
                cmd.div_sel_below = 1'b1;
                state_next        = S_DIVB_WAIT;
            end
            S_DIVB_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.store_gb = 1'b1;
                    state_next   = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_ACC2;
            end
            S_ACC2:
            begin
                cmd.acc2   = 1'b1;
                state_next = S_DIVS_GO;
            end
            S_DIVS_GO:
            begin
                cmd.div_start     = 1'b1;
                cmd.div_sel_solve = 1'b1;
                state_next        = S_DIVS_WAIT;
            end
            S_DIVS_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (!kind_reg && stat.last)
                    begin
                        // The top layer's result reuses the coupling just found.
                        kind_next  = 1'b1;
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        cmd.shift  = (stat.held != 2'd0);
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/vertical_diffusion_jacobi_sweep.sv */
// ----------------------------------------------------------------------------
// vertical_diffusion_jacobi_sweep
// One Jacobi sweep of vertical diffusion over a column of layers.
//
// Channel   Direction  Handshake            Payload
// layer in  input      in_valid / in_stall  layer_thickness, layer_value,
//                                           layer_rhs, last_layer
// result    output     out_valid/out_stall  new_value, column_done, saturated
// config    input      cfg_we               cfg_index, cfg_data
//
// A layer that only opens a column is just stored. Each division holds the
// shared divider through a start and a wait state; the couplings share one
// product, one or two neighbors add one or two coupling divisions, a top layer
// gets a second result, and each result adds multiply-accumulate and output steps.
// Output stalls delay the hand-off; a new layer is accepted while a result still waits.
// Reset clears the window and the controller; registers return to 1.0.
// ----------------------------------------------------------------------------
module vertical_diffusion_jacobi_sweep (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [vdj_pkg::REG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [vdj_pkg::THICK_W-1:0]        layer_thickness,
    input  logic signed [vdj_pkg::VALUE_W-1:0] layer_value,
    input  logic signed [vdj_pkg::VALUE_W-1:0] layer_rhs,
    input  logic                               last_layer,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [vdj_pkg::VALUE_W-1:0] new_value,
    output logic                               column_done,
    output logic                               saturated
);

    vdj_pkg::vdj_cmd_t  cmd;
    vdj_pkg::vdj_stat_t stat;

    vdj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    vdj_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .layer_thickness (layer_thickness),
        .layer_value     (layer_value),
        .layer_rhs       (layer_rhs),
        .last_layer      (last_layer),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .new_value       (new_value),
        .column_done     (column_done),
        .saturated       (saturated)
    );

    // A division is never restarted while one is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_busy |-> !cmd.div_start)
        else $error("divider started while busy");

    // A result is only written when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || !out_stall))
        else $error("result overwrote a pending output");

    // Once a request is accepted, the next one waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vertical diffusion Jacobi sweep. Columns of
// layers are sent under several viscosity and time step settings. A bit-true
// predictor of the sweep checks every result in order. Both channels idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 300;
    localparam int LONG_HOLD       = 3000;

    typedef struct {
        logic signed [vdj_pkg::VALUE_W-1:0] value;
        logic                               done;
        logic                               sat;
    } layer_result_t;

    typedef struct {
        logic [vdj_pkg::THICK_W-1:0]        dz;
        logic signed [vdj_pkg::VALUE_W-1:0] x;
        logic signed [vdj_pkg::VALUE_W-1:0] rhs;
        logic                               last;
        bit                                 typed;
        layer_result_t                      want;
    } layer_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic                               cfg_index;
    logic [vdj_pkg::REG_W-1:0]          cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    logic [vdj_pkg::THICK_W-1:0]        layer_thickness;
    logic signed [vdj_pkg::VALUE_W-1:0] layer_value;
    logic signed [vdj_pkg::VALUE_W-1:0] layer_rhs;
    logic                               last_layer;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [vdj_pkg::VALUE_W-1:0] new_value;
    logic                               column_done;
    logic                               saturated;

    vertical_diffusion_jacobi_sweep dut (.*);

    // Sweep predictor: configuration and the three-layer window.
    logic [63:0] visc_r, tstep_r;
    int          held;
    logic [63:0] dz_below, dz_mid;
    longint      x_below, x_mid, rhs_held;

    layer_result_t pending_results[$];
    int  mismatches, layers_sent, results_seen, columns_sent, settings_used;
    bit  quiet, hold_req;
    int  idle_cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] coupling_of(logic [63:0] a, logic [63:0] b);
        logic [63:0] p, s, q, r, g, gmax;
        gmax = 64'(vdj_pkg::COUPLING_MAX);
        p = visc_r * tstep_r;
        s = a + b;
        q = p / s;
        r = p % s;
        if (q >= gmax)
            return gmax;
        g = 2 * q + ((2 * r >= s) ? 64'd1 : 64'd0);
        return (g > gmax) ? gmax : g;
    endfunction

    function automatic layer_result_t solve_layer(logic [63:0] dz, longint rhs,
                                                  logic [63:0] gb, longint xb,
                                                  logic [63:0] ga, longint xa,
                                                  logic done);
        layer_result_t res;
        longint        num;
        logic [63:0]   den, mag, q, lim;
        bit            neg;
        num = longint'(gb) * xb + longint'(ga) * xa
            + rhs * (64'sd1 <<< vdj_pkg::FRAC_BITS);
        den = gb + ga + dz;
        neg = num < 0;
        mag = neg ? 64'(-num) : 64'(num);
        lim = 64'd1 << (vdj_pkg::VALUE_W - 1);
        q = mag / den;
        res.sat = 1'b0;
        if (neg)
        begin
            if (q > lim)
            begin
                q = lim;
                res.sat = 1'b1;
            end
            res.value = vdj_pkg::VALUE_W'(~q + 64'd1);
        end
        else
        begin
            if (q > lim - 1)
            begin
                q = lim - 1;
                res.sat = 1'b1;
            end
            res.value = vdj_pkg::VALUE_W'(q);
        end
        res.done = done;
        return res;
    endfunction

    // Advance the window by one accepted layer and queue what it releases.
    task automatic predict_layer(layer_row_t row);
        logic [63:0] dz, ga, gb;
        longint      x, rhs;
        dz  = (row.dz == 0) ? 64'd1 : 64'(row.dz);
        x   = row.x;
        rhs = row.rhs;
        if (row.last)
            columns_sent++;
        if (held == 0)
        begin
            if (row.last)
            begin
                pending_results.push_back(solve_layer(dz, rhs, 0, 0, 0, 0, 1'b1));
            end
            else
            begin
                dz_mid = dz;
                x_mid = x;
                rhs_held = rhs;
                held = 1;
            end
        end
        else
        begin
            ga = coupling_of(dz_mid, dz);
            gb = (held >= 2) ? coupling_of(dz_mid, dz_below) : 64'd0;
            pending_results.push_back(solve_layer(dz_mid, rhs_held, gb, x_below,
                                                  ga, x, 1'b0));
            dz_below = dz_mid;
            x_below = x_mid;
            dz_mid = dz;
            x_mid = x;
            rhs_held = rhs;
            if (row.last)
            begin
                gb = coupling_of(dz_mid, dz_below);
                pending_results.push_back(solve_layer(dz_mid, rhs_held, gb, x_below,
                                                      0, 0, 1'b1));
                held = 0;
            end
            else
            begin
                held = 2;
            end
        end
        // Rows with a hand-worked answer replace the single predicted result.
        if (row.typed)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(row.want);
        end
    endtask

    function automatic int idle_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    task automatic send_layer(layer_row_t row);
        int gap;
        in_valid        <= 1'b1;
        layer_thickness <= row.dz;
        layer_value     <= row.x;
        layer_rhs       <= row.rhs;
        last_layer      <= row.last;
        do
            @(posedge clk);
        while (in_stall);
        predict_layer(row);
        layers_sent++;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_settings(logic [vdj_pkg::REG_W-1:0] visc,
                                  logic [vdj_pkg::REG_W-1:0] tstep);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= vdj_pkg::CFG_VISCOSITY;
        cfg_data  <= visc;
        @(posedge clk);
        cfg_index <= vdj_pkg::CFG_TIME_STEP;
        cfg_data  <= tstep;
        @(posedge clk);
        cfg_we <= 1'b0;
        visc_r  = 64'(visc);
        tstep_r = 64'(tstep);
        settings_used++;
    endtask

    function automatic logic [vdj_pkg::THICK_W-1:0] pick_thickness();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return $urandom;
            2: return $urandom_range(1, 32'hFFFF);
            3: return 32'h10000 + $urandom_range(0, 32'h3FFFF);
            4: return 32'hFFFFFFFF - $urandom_range(0, 15);
            default: return $urandom_range(32'h8000, 32'h80000);
        endcase
    endfunction

    function automatic logic [vdj_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFFFFFF - $urandom_range(0, 3);
            2: return 32'h80000000 + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 32'h1FFFFF)) - 32'h100000);
        endcase
    endfunction

    task automatic send_random_columns(int layer_count);
        layer_row_t row;
        int         depth, k, sent;
        sent = 0;
        while (sent < layer_count)
        begin
            // Mostly short columns, sometimes a lone layer or a deep one.
            depth = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                : $urandom_range(1, 6);
            for (k = 0; k < depth; k++)
            begin
                row.dz    = pick_thickness();
                row.x     = pick_value();
                row.rhs   = pick_value();
                row.last  = (k == depth - 1);
                row.typed = 0;
                send_layer(row);
            end
            sent += depth;
        end
    endtask

    // Result side: checks every accepted result and drives the stall.
    initial
    begin
        layer_result_t want;
        int            stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value=%h done=%b sat=%b",
                                 new_value, column_done, saturated);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (new_value !== want.value || column_done !== want.done ||
                        saturated !== want.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: want %h/%b/%b got %h/%b/%b",
                                     results_seen, want.value, want.done, want.sat,
                                     new_value, column_done, saturated);
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0)
            begin
                stall_left = idle_len();
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        layer_row_t directed[$];
        layer_row_t row;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= vdj_pkg::CFG_VISCOSITY;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        layer_thickness <= '0;
        layer_value     <= '0;
        layer_rhs       <= '0;
        last_layer      <= 1'b0;
        visc_r  = 64'h10000;
        tstep_r = 64'h10000;
        held = 0;
        dz_below = 0;
        dz_mid = 0;
        x_below = 0;
        x_mid = 0;
        rhs_held = 0;

        // Lone layers with answers worked by hand, then mixed columns.
        directed = '{
            '{32'h00010000, 32'h0, 32'h00050000, 1, 1, '{32'h00050000, 1, 0}},
            '{32'h00000000, 32'h0, 32'h7FFFFFFF, 1, 1, '{32'h7FFFFFFF, 1, 1}},
            '{32'h00000000, 32'h0, 32'h80000000, 1, 1, '{32'h80000000, 1, 1}},
            '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0, 1, 1, '{32'h0, 1, 0}},
            '{32'h00020000, 32'h0, 32'hFFFC0000, 1, 1, '{32'hFFFE0000, 1, 0}},
            '{32'h00010000, 32'h00010000, 32'h0, 0, 0, '{0, 0, 0}},
            '{32'h00010000, 32'h00020000, 32'h0, 1, 0, '{0, 0, 0}},
            '{32'h00000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, '{0, 0, 0}},
            '{32'hFFFFFFFF, 32'h80000000, 32'h80000000, 0, 0, '{0, 0, 0}},
            '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, '{0, 0, 0}},
            '{32'h00000001, 32'h80000000, 32'h7FFFFFFF, 0, 0, '{0, 0, 0}},
            '{32'h00008000, 32'h00030000, 32'hFFFF0000, 1, 0, '{0, 0, 0}},
            '{32'h00000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, '{0, 0, 0}},
            '{32'h00000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, '{0, 0, 0}},
            '{32'h00000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 0, '{0, 0, 0}},
            '{32'h00040000, 32'h00100000, 32'h00000000, 0, 0, '{0, 0, 0}},
            '{32'h00010000, 32'hFFF00000, 32'h00010000, 0, 0, '{0, 0, 0}},
            '{32'h00020000, 32'h00080000, 32'h00020000, 0, 0, '{0, 0, 0}},
            '{32'h00010000, 32'h00000000, 32'hFFFE0000, 1, 0, '{0, 0, 0}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_layer(directed[i]);

        // Reset settings, with the long output hold early on.
        hold_req = 1;
        send_random_columns(180);

        write_settings('0, '0);
        send_random_columns(150);
        // Same columns with the largest coupling the block can form.
        write_settings(32'hFFFFFFFF, 32'hFFFFFFFF);
        for (int i = 5; i < directed.size(); i++)
        begin
            row = directed[i];
            send_layer(row);
        end
        send_random_columns(150);

        write_settings(32'h1, 32'hFFFFFFFF);
        quiet = 1;
        send_random_columns(150);
        quiet = 0;

        write_settings($urandom, $urandom);
        send_random_columns(150);
        write_settings($urandom_range(32'h100, 32'h100000), $urandom_range(32'h100, 32'h100000));
        send_random_columns(150);

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Swept %0d layers in %0d columns under %0d register settings,",
                 layers_sent, columns_sent, settings_used + 1);
        $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
